/* rtl/mmp_pkg.sv */
package mmp_pkg;

	// One input transaction: a MIDI byte or a breath curve write.
	typedef struct packed {
		logic       operation;
		logic [7:0] midi_byte;
		logic [6:0] curve_index;
		logic [6:0] curve_value;
	} item_t;

	// One decoded event.
	typedef struct packed {
		logic [2:0] event_kind;
		logic [3:0] channel;
		logic [6:0] first_value;
		logic [6:0] second_value;
	} result_t;

	// Decoded event on its way to the output stage.
	typedef struct packed {
		logic    valid;
		logic    use_curve;
		result_t res;
	} event_t;

	// Settings held by the configuration registers.
	typedef struct packed {
		logic [7:0] key_offset;
		logic [1:0] wind_mode;
	} cfg_t;

	localparam int unsigned CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_OFFSET = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_WIND_MODE  = 1'd1;

	localparam logic [0:0] OP_MIDI_BYTE   = 1'b0;
	localparam logic [0:0] OP_CURVE_WRITE = 1'b1;

	localparam logic [2:0] KIND_NOTE_ON    = 3'd0;
	localparam logic [2:0] KIND_NOTE_OFF   = 3'd1;
	localparam logic [2:0] KIND_CONTROL    = 3'd2;
	localparam logic [2:0] KIND_PITCH_BEND = 3'd3;
	localparam logic [2:0] KIND_PROGRAM    = 3'd4;
	localparam logic [2:0] KIND_PRESSURE   = 3'd5;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_DATA1 = 2'd1;
	localparam logic [1:0] PH_DATA2 = 2'd2;
	localparam logic [1:0] PH_SYSEX = 2'd3;

	localparam logic [1:0] WIND_PLAIN = 2'd0;
	localparam logic [1:0] WIND_REMAP = 2'd1;
	localparam logic [1:0] WIND_FIXED = 2'd2;

	localparam logic [7:0] ST_NONE      = 8'h00;
	localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
	localparam logic [7:0] ST_NOTE_ON   = 8'h90;
	localparam logic [7:0] ST_CONTROL   = 8'hB0;
	localparam logic [7:0] ST_PROGRAM   = 8'hC0;
	localparam logic [7:0] ST_PRESSURE  = 8'hD0;
	localparam logic [7:0] ST_BEND      = 8'hE0;
	localparam logic [7:0] ST_SYSEX     = 8'hF0;
	localparam logic [7:0] ST_TIME_CODE = 8'hF1;
	localparam logic [7:0] ST_SONG_POS  = 8'hF2;
	localparam logic [7:0] ST_SONG_SEL  = 8'hF3;
	localparam logic [7:0] ST_EOX       = 8'hF7;
	localparam logic [7:0] ST_REALTIME  = 8'hF8;

	localparam logic [7:0] STATUS_MASK  = 8'hF0;
	localparam logic [7:0] CHANNEL_MASK = 8'h0F;

	localparam logic [6:0] BREATH_CTL      = 7'd2;
	localparam logic [6:0] BREATH_CTL_LSB  = 7'd34;
	localparam logic [6:0] BREATH_REMAP    = 7'd5;
	localparam logic [6:0] FIXED_VELOCITY  = 7'd100;

endpackage

/* rtl/mmp_decode.sv */
module mmp_decode (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  mmp_pkg::item_t item,
	input  mmp_pkg::cfg_t  cfg,
	output mmp_pkg::event_t ev
);

	logic [7:0] status_q, status_d;
	logic [3:0] channel_q, channel_d;
	logic [1:0] phase_q, phase_d;
	logic [6:0] held_q, held_d;

	logic [7:0] b;
	logic [8:0] note_sum;
	logic       note_ok;
	logic       wind_on;
	logic       one_data;

	assign b = item.midi_byte;
	// Held note plus signed offset spans -128..254, so nine bits.
	assign note_sum = {2'b00, held_q} + {cfg.key_offset[7], cfg.key_offset};
	assign note_ok  = (note_sum[8:7] == 2'b00);
	assign wind_on  = (cfg.wind_mode == mmp_pkg::WIND_REMAP) ||
	                  (cfg.wind_mode == mmp_pkg::WIND_FIXED);
	assign one_data = (status_q == mmp_pkg::ST_PROGRAM) ||
	                  (status_q == mmp_pkg::ST_PRESSURE);

	always_comb begin
		status_d     = status_q;
		channel_d    = channel_q;
		phase_d      = phase_q;
		held_d       = held_q;
		ev.valid     = 1'b0;
		ev.use_curve = 1'b0;
		ev.res.event_kind   = mmp_pkg::KIND_NOTE_ON;
		ev.res.channel      = channel_q;
		ev.res.first_value  = b[6:0];
		ev.res.second_value = 7'd0;
		if (item.operation == mmp_pkg::OP_CURVE_WRITE) begin
			// The curve memory takes this transaction.
		end else if (b[7]) begin
			priority if (b >= mmp_pkg::ST_REALTIME) begin
				// Real-time bytes leave the parser untouched.
			end else if (b == mmp_pkg::ST_EOX) begin
				phase_d = mmp_pkg::PH_IDLE;
			end else if (b == mmp_pkg::ST_SYSEX) begin
				status_d = b;
				phase_d  = mmp_pkg::PH_SYSEX;
			end else if (b == mmp_pkg::ST_TIME_CODE || b == mmp_pkg::ST_SONG_POS ||
			             b == mmp_pkg::ST_SONG_SEL) begin
				status_d = b;
				phase_d  = mmp_pkg::PH_DATA1;
			end else if (b > mmp_pkg::ST_SONG_SEL) begin
				status_d = b;
				phase_d  = mmp_pkg::PH_IDLE;
			end else begin
				status_d  = b & mmp_pkg::STATUS_MASK;
				channel_d = b[3:0];
				phase_d   = mmp_pkg::PH_DATA1;
			end
		end else begin
			unique case (phase_q)
				mmp_pkg::PH_DATA1: begin
					held_d = b[6:0];
					if (one_data) begin
						phase_d  = mmp_pkg::PH_IDLE;
						ev.valid = 1'b1;
						ev.res.event_kind = (status_q == mmp_pkg::ST_PROGRAM) ?
						                    mmp_pkg::KIND_PROGRAM : mmp_pkg::KIND_PRESSURE;
					end else if (status_q == mmp_pkg::ST_TIME_CODE ||
					             status_q == mmp_pkg::ST_SONG_SEL) begin
						phase_d = mmp_pkg::PH_IDLE;
					end else begin
						phase_d = mmp_pkg::PH_DATA2;
					end
				end
				mmp_pkg::PH_DATA2: begin
					phase_d = mmp_pkg::PH_IDLE;
					if (status_q == mmp_pkg::ST_NOTE_ON || status_q == mmp_pkg::ST_NOTE_OFF) begin
						ev.valid = note_ok;
						ev.res.first_value = note_sum[6:0];
						if (status_q == mmp_pkg::ST_NOTE_OFF || b[6:0] == 7'd0) begin
							ev.res.event_kind = mmp_pkg::KIND_NOTE_OFF;
						end else begin
							ev.res.event_kind   = mmp_pkg::KIND_NOTE_ON;
							ev.res.second_value = (cfg.wind_mode == mmp_pkg::WIND_FIXED) ?
							                      mmp_pkg::FIXED_VELOCITY : b[6:0];
						end
					end else if (status_q == mmp_pkg::ST_CONTROL) begin
						ev.valid            = 1'b1;
						ev.res.event_kind   = mmp_pkg::KIND_CONTROL;
						ev.res.first_value  = held_q;
						ev.res.second_value = b[6:0];
						if (wind_on && (held_q == mmp_pkg::BREATH_CTL ||
						                held_q == mmp_pkg::BREATH_CTL_LSB)) begin
							ev.use_curve       = 1'b1;
							ev.res.first_value = held_q + mmp_pkg::BREATH_REMAP;
						end
					end else if (status_q == mmp_pkg::ST_BEND) begin
						ev.valid            = 1'b1;
						ev.res.event_kind   = mmp_pkg::KIND_PITCH_BEND;
						ev.res.first_value  = held_q;
						ev.res.second_value = b[6:0];
					end
				end
				mmp_pkg::PH_IDLE: begin
					// Running status: a data byte restarts the current message.
					if (status_q[7] && status_q < mmp_pkg::ST_SYSEX) begin
						held_d = b[6:0];
						if (one_data) begin
							ev.valid = 1'b1;
							ev.res.event_kind = (status_q == mmp_pkg::ST_PROGRAM) ?
							                    mmp_pkg::KIND_PROGRAM : mmp_pkg::KIND_PRESSURE;
						end else begin
							phase_d = mmp_pkg::PH_DATA2;
						end
					end
				end
				mmp_pkg::PH_SYSEX: begin
					// Exclusive data is skipped.
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q  <= mmp_pkg::ST_NONE;
			channel_q <= 4'd0;
			phase_q   <= mmp_pkg::PH_IDLE;
			held_q    <= 7'd0;
		end else if (accept) begin
			status_q  <= status_d;
			channel_q <= channel_d;
			phase_q   <= phase_d;
			held_q    <= held_d;
		end
	end

	a_realtime_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.operation == mmp_pkg::OP_MIDI_BYTE && item.midi_byte >= mmp_pkg::ST_REALTIME
		|=> $stable(phase_q) && $stable(status_q) && $stable(held_q))
		else $error("real-time byte changed parser state");

	a_curve_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		item.operation == mmp_pkg::OP_CURVE_WRITE |-> !ev.valid)
		else $error("curve write produced an event");

	a_curve_only_control: assert property (@(posedge clk) disable iff (!arst_n)
		ev.use_curve |-> ev.valid && ev.res.event_kind == mmp_pkg::KIND_CONTROL)
		else $error("curve lookup on a non-control event");

	a_sysex_silent: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == mmp_pkg::PH_SYSEX && !item.midi_byte[7] |-> !ev.valid)
		else $error("event produced inside exclusive data");

endmodule

/* rtl/mmp_curve.sv */
module mmp_curve (
	input  logic       clk,
	input  logic       wr_en,
	input  logic [6:0] wr_addr,
	input  logic [6:0] wr_data,
	input  logic       rd_en,
	input  logic [6:0] rd_addr,
	output logic [6:0] rd_data_s1
);

	logic [6:0] mem [128];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

endmodule

/* rtl/mmp_out.sv */
module mmp_out (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  mmp_pkg::event_t  ev,
	input  logic [6:0]       curve_s1,
	output logic             hold,
	output mmp_pkg::result_t result,
	output logic             result_valid,
	input  logic             result_stall
);

	logic             ev_valid_s1;
	logic             use_curve_s1;
	mmp_pkg::result_t res_s1;
	logic             load;

	assign load = !result_valid || !result_stall;
	// Decode stage is full and cannot drain into the output register.
	assign hold = ev_valid_s1 && !load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid_s1 <= 1'b0;
		end else if (accept) begin
			ev_valid_s1 <= ev.valid;
		end else if (load) begin
			ev_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			use_curve_s1 <= ev.use_curve;
			res_s1       <= ev.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (load) begin
			result_valid <= ev_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && ev_valid_s1) begin
			result.event_kind   <= res_s1.event_kind;
			result.channel      <= res_s1.channel;
			result.first_value  <= res_s1.first_value;
			result.second_value <= use_curve_s1 ? curve_s1 : res_s1.second_value;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("stalled result was dropped");

	a_hold_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		hold |-> ev_valid_s1 && result_valid)
		else $error("input stalled with room downstream");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.event_kind <= mmp_pkg::KIND_PRESSURE)
		else $error("event kind out of range");

endmodule

/* rtl/midi_message_parser.sv */
// An event passes the first stage register and the output register to result.
// Throughput: while nothing stalls, one transaction per cycle; the decoder,
// the breath curve read and the output register each take one item per clock.
// Reset (arst_n low): running status cleared, phase idle, configuration zero.
// The breath curve memory is not cleared and must be written before use.
module midi_message_parser (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mmp_pkg::item_t                   item,
	input  logic                             item_valid,
	output logic                             item_stall,
	output mmp_pkg::result_t                 result,
	output logic                             result_valid,
	input  logic                             result_stall,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mmp_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [7:0]                       cfg_data
);

	// Configuration registers. The user must make writes only while the block is
	// idle; the block itself does not enforce this, and the port is always ready.
	mmp_pkg::cfg_t   cfg_q;
	mmp_pkg::event_t ev;
	logic            accept;
	logic            hold;
	logic [6:0]      curve_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_offset <= 8'd0;
			cfg_q.wind_mode  <= mmp_pkg::WIND_PLAIN;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mmp_pkg::CFG_KEY_OFFSET: cfg_q.key_offset <= cfg_data;
				mmp_pkg::CFG_WIND_MODE:  cfg_q.wind_mode  <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	// The input side stalls only when a decoded event waits in the first stage
	// and the output register is itself full and stalled, so a transaction can
	// still be taken while a finished result waits to be collected.
	assign item_stall = hold;
	assign accept     = item_valid && !item_stall;

	// The parser decodes the byte against its running status in the same
	// cycle that the transaction is accepted, and the decoded event is
	// registered in the first stage.
	mmp_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.cfg    (cfg_q),
		.ev     (ev)
	);

	// The breath curve is read at every accepted MIDI byte, status or data; the
	// output stage only uses the value for a remapped breath controller. A
	// curve write and a read never fall on the same transaction.
	mmp_curve u_curve (
		.clk        (clk),
		.wr_en      (accept && item.operation == mmp_pkg::OP_CURVE_WRITE),
		.wr_addr    (item.curve_index),
		.wr_data    (item.curve_value),
		.rd_en      (accept && item.operation == mmp_pkg::OP_MIDI_BYTE),
		.rd_addr    (item.midi_byte[6:0]),
		.rd_data_s1 (curve_s1)
	);

	// The output stage merges the curve value into the event and holds the
	// result until it has been taken.
	mmp_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.ev           (ev),
		.curve_s1     (curve_s1),
		.hold         (hold),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

endmodule
